>>> rtl/nsp_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and the crc byte update for the nit section parser
package nsp_pkg;

  localparam int BYTE_W      = 8;
  localparam int SEC_W       = 8;
  localparam int LEN_W       = 12;
  localparam int ID_W        = 16;
  localparam int TABLE_ID_W  = 8;
  localparam int SEEN_GRP_W  = 4;

  localparam logic [TABLE_ID_W-1:0] TABLE_ID_RESET = 8'h40;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // result kinds
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_NET_DESC = 3'd1;
  localparam logic [2:0] KIND_ENTRY    = 3'd2;
  localparam logic [2:0] KIND_ENT_DESC = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;

  // end status codes
  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_CRC_ERR     = 3'd1;
  localparam logic [2:0] STAT_OVERRUN     = 3'd2;
  localparam logic [2:0] STAT_DUPLICATE   = 3'd3;
  localparam logic [2:0] STAT_WRONG_TABLE = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEADER,
    PH_NETDESC,
    PH_LOOPHI,
    PH_LOOPLO,
    PH_ENTHDR,
    PH_ENTDESC,
    PH_TRAILER,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] data_byte;
    logic              section_start;
    logic              section_end;
  } nsp_in_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ID_W-1:0]   network_id;
    logic [SEC_W-1:0]  section_number;
    logic [SEC_W-1:0]  last_section_number;
    logic [ID_W-1:0]   stream_id;
    logic [ID_W-1:0]   orig_network_id;
    logic [LEN_W-1:0]  desc_length;
    logic [BYTE_W-1:0] out_byte;
    logic [2:0]        status;
    logic              table_complete;
  } nsp_out_t;

  typedef struct packed {
    logic             clear;
    logic             set;
    logic [SEC_W-1:0] set_idx;
    logic [SEC_W-1:0] query_idx;
    logic [SEC_W-1:0] last_idx;
  } seen_req_t;

  typedef struct packed {
    logic hit;
    logic query_bad;
    logic done;
  } seen_resp_t;

  // crc-32/mpeg-2, msb first, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [BYTE_W-1:0] b);
    logic [31:0] c;
    logic        top;
    c = crc_in;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      top = c[31] ^ b[i];
      c = {c[30:0], 1'b0};
      if (top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/nsp_seen.sv
`timescale 1ns / 1ps
// bitmap of sections already seen, with registered per-group full flags
module nsp_seen #(
  parameter int MAX_SECTIONS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  nsp_pkg::seen_req_t  req,
  output nsp_pkg::seen_resp_t resp
);

  localparam int SEC_W    = nsp_pkg::SEC_W;
  localparam int MAP_W    = ($clog2(MAX_SECTIONS) > 5) ? $clog2(MAX_SECTIONS) : 5;
  localparam int MAP_BITS = 1 << MAP_W;
  localparam int GRP_W    = nsp_pkg::SEEN_GRP_W;
  localparam int GRP_SIZE = 1 << GRP_W;
  localparam int NGRP     = MAP_BITS / GRP_SIZE;
  localparam int GI_W     = MAP_W - GRP_W;
  localparam logic [SEC_W:0] SEC_LIMIT = (SEC_W + 1)'(MAX_SECTIONS);

  logic [MAP_BITS-1:0] seen_map;
  logic [MAP_BITS-1:0] seen_map_next;
  logic [NGRP-1:0]     grp_full;
  logic [NGRP-1:0]     grp_full_next;
  logic [NGRP-1:0]     grp_chk;

  logic [MAP_W-1:0]    set_pos;
  logic [MAP_W-1:0]    qry_pos;
  logic [MAP_W-1:0]    last_pos;
  logic [GI_W-1:0]     set_grp;
  logic [GI_W-1:0]     last_grp;
  logic [GRP_SIZE-1:0] set_bit;
  logic [GRP_SIZE-1:0] set_grp_bits;
  logic [GRP_SIZE-1:0] last_grp_bits;
  logic [GRP_SIZE-1:0] last_le_mask;
  logic                set_grp_full;
  logic [NGRP-1:0]     eff_full;
  logic [NGRP-1:0]     below_mask;
  logic                qry_in_range;
  logic                last_in_range;

  assign set_pos  = req.set_idx[MAP_W-1:0];
  assign qry_pos  = req.query_idx[MAP_W-1:0];
  assign last_pos = req.last_idx[MAP_W-1:0];
  assign set_grp  = set_pos[MAP_W-1:GRP_W];
  assign last_grp = last_pos[MAP_W-1:GRP_W];

  assign qry_in_range  = {1'b0, req.query_idx} < SEC_LIMIT;
  assign last_in_range = {1'b0, req.last_idx} < SEC_LIMIT;

  assign set_bit      = {{(GRP_SIZE-1){1'b0}}, 1'b1} << set_pos[GRP_W-1:0];
  assign set_grp_bits = seen_map[{set_grp, {GRP_W{1'b0}}} +: GRP_SIZE] | set_bit;
  assign set_grp_full = &set_grp_bits;

  // group flags as they stand once this cycle's set has landed
  assign eff_full = grp_full |
                    ((req.set && set_grp_full) ? ({{(NGRP-1){1'b0}}, 1'b1} << set_grp)
                                               : {NGRP{1'b0}});

  assign last_grp_bits = seen_map[{last_grp, {GRP_W{1'b0}}} +: GRP_SIZE] |
                         ((req.set && (set_grp == last_grp)) ? set_bit : {GRP_SIZE{1'b0}});

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      below_mask[g] = GI_W'(g) < last_grp;
    end
    for (int k = 0; k < GRP_SIZE; k++) begin
      last_le_mask[k] = GRP_W'(k) <= last_pos[GRP_W-1:0];
    end
  end

  assign resp.hit       = qry_in_range && seen_map[qry_pos];
  assign resp.query_bad = !qry_in_range;
  assign resp.done      = last_in_range && (&(eff_full | ~below_mask)) &&
                          (&(last_grp_bits | ~last_le_mask));

  always_comb begin
    seen_map_next = seen_map;
    grp_full_next = grp_full;
    if (req.clear) begin
      seen_map_next = '0;
      grp_full_next = '0;
    end else if (req.set) begin
      seen_map_next = seen_map | ({{(MAP_BITS-1){1'b0}}, 1'b1} << set_pos);
      grp_full_next = eff_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_map <= '0;
      grp_full <= '0;
    end else begin
      seen_map <= seen_map_next;
      grp_full <= grp_full_next;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_chk[g] = &seen_map[g*GRP_SIZE +: GRP_SIZE];
    end
  end

  a_grp_flags_track_map : assert property (@(posedge clk) disable iff (rst)
    grp_full == grp_chk)
    else $error("group full flags out of step with seen map");

  a_clear_empties_map : assert property (@(posedge clk) disable iff (rst)
    req.clear |=> (seen_map == '0))
    else $error("restart left sections marked as seen");

endmodule

>>> rtl/nsp_parse.sv
`timescale 1ns / 1ps
// section byte parser: phase sequencing, crc, field capture and result forming
module nsp_parse (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  nsp_pkg::nsp_in_t                      item,
  input  logic [nsp_pkg::TABLE_ID_W-1:0]        expected_table_id,
  input  nsp_pkg::seen_resp_t                   seen_resp,
  output nsp_pkg::seen_req_t                    seen_req,
  output logic                                  res_valid,
  output nsp_pkg::nsp_out_t                     res
);

  localparam int LEN_W = nsp_pkg::LEN_W;
  localparam logic [LEN_W-1:0] POS_LEN_HI   = 12'd1;
  localparam logic [LEN_W-1:0] POS_LEN_LO   = 12'd2;
  localparam logic [LEN_W-1:0] POS_NET_HI   = 12'd3;
  localparam logic [LEN_W-1:0] POS_NET_LO   = 12'd4;
  localparam logic [LEN_W-1:0] POS_SEC      = 12'd6;
  localparam logic [LEN_W-1:0] POS_LAST     = 12'd7;
  localparam logic [LEN_W-1:0] POS_NDL_HI   = 12'd8;
  localparam logic [LEN_W-1:0] POS_NDL_LO   = 12'd9;
  localparam logic [LEN_W-1:0] POS_MAX      = 12'hFFF;
  localparam logic [LEN_W-1:0] ENT_HDR_LEN  = 12'd6;
  localparam logic [LEN_W-1:0] TRAILER_LEN  = 12'd4;

  nsp_pkg::phase_t  phase, phase_next;
  logic [LEN_W-1:0] pos, pos_next;
  logic [LEN_W-1:0] net_rem, net_rem_next;
  logic [LEN_W-1:0] loop_rem, loop_rem_next;
  logic [LEN_W-1:0] ent_rem, ent_rem_next;
  logic [47:0]      scratch, scratch_next;
  logic [15:0]      net_id, net_id_next;
  logic [7:0]       sec_num, sec_num_next;
  logic [7:0]       last_num, last_num_next;
  logic [LEN_W-1:0] sec_len, sec_len_next;
  logic [31:0]      crc, crc_next;
  logic             flag_ovr, flag_ovr_next;
  logic             flag_dup, flag_dup_next;

  logic [LEN_W-1:0] ent_len;
  logic             overrun;
  logic [7:0]       d;

  assign d = item.data_byte;

  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    net_rem_next  = net_rem;
    loop_rem_next = loop_rem;
    ent_rem_next  = ent_rem;
    scratch_next  = scratch;
    net_id_next   = net_id;
    sec_num_next  = sec_num;
    last_num_next = last_num;
    sec_len_next  = sec_len;
    crc_next      = crc;
    flag_ovr_next = flag_ovr;
    flag_dup_next = flag_dup;
    ent_len       = '0;
    overrun       = 1'b0;
    res_valid     = 1'b0;
    res           = '0;
    seen_req      = '0;
    seen_req.query_idx = d;

    if (step) begin
      if (item.req_type) begin
        seen_req.clear = 1'b1;
        phase_next     = nsp_pkg::PH_IDLE;
      end else if (item.section_start || phase != nsp_pkg::PH_IDLE) begin
        if (item.section_start) begin
          pos_next      = '0;
          net_rem_next  = '0;
          loop_rem_next = '0;
          ent_rem_next  = '0;
          scratch_next  = '0;
          net_id_next   = '0;
          sec_num_next  = '0;
          last_num_next = '0;
          sec_len_next  = '0;
          flag_ovr_next = 1'b0;
          flag_dup_next = 1'b0;
          crc_next      = nsp_pkg::crc_byte(nsp_pkg::CRC_INIT, d);
          phase_next    = (d == expected_table_id) ? nsp_pkg::PH_HEADER : nsp_pkg::PH_SKIP;
        end else begin
          // position saturates; hitting the ceiling counts as an overrun
          if (pos == POS_MAX) begin
            flag_ovr_next = 1'b1;
          end else begin
            pos_next = pos + 12'd1;
          end
          crc_next = nsp_pkg::crc_byte(crc, d);
          case (phase)
            nsp_pkg::PH_HEADER: begin
              case (pos_next)
                POS_LEN_HI: sec_len_next = {d[3:0], 8'h00};
                POS_LEN_LO: sec_len_next = sec_len | {4'h0, d};
                POS_NET_HI: net_id_next  = {d, net_id[7:0]};
                POS_NET_LO: net_id_next  = {net_id[15:8], d};
                POS_SEC: begin
                  sec_num_next = d;
                  if (seen_resp.query_bad) begin
                    flag_ovr_next = 1'b1;
                  end else if (seen_resp.hit) begin
                    flag_dup_next = 1'b1;
                  end
                end
                POS_LAST:   last_num_next = d;
                POS_NDL_HI: net_rem_next  = {d[3:0], 8'h00};
                POS_NDL_LO: begin
                  net_rem_next = net_rem | {4'h0, d};
                  phase_next   = (net_rem_next != '0) ? nsp_pkg::PH_NETDESC
                                                      : nsp_pkg::PH_LOOPHI;
                  if (!flag_dup) begin
                    res_valid       = 1'b1;
                    res.kind        = nsp_pkg::KIND_HEADER;
                    res.desc_length = net_rem_next;
                  end
                end
                default: ;
              endcase
            end
            nsp_pkg::PH_NETDESC: begin
              net_rem_next = net_rem - 12'd1;
              if (net_rem_next == '0) begin
                phase_next = nsp_pkg::PH_LOOPHI;
              end
              if (!flag_dup) begin
                res_valid    = 1'b1;
                res.kind     = nsp_pkg::KIND_NET_DESC;
                res.out_byte = d;
              end
            end
            nsp_pkg::PH_LOOPHI: begin
              loop_rem_next = {d[3:0], 8'h00};
              phase_next    = nsp_pkg::PH_LOOPLO;
            end
            nsp_pkg::PH_LOOPLO: begin
              loop_rem_next = loop_rem | {4'h0, d};
              ent_rem_next  = '0;
              phase_next    = (loop_rem_next == '0) ? nsp_pkg::PH_TRAILER
                                                    : nsp_pkg::PH_ENTHDR;
            end
            nsp_pkg::PH_ENTHDR: begin
              scratch_next  = {scratch[39:0], d};
              ent_rem_next  = ent_rem + 12'd1;
              loop_rem_next = loop_rem - 12'd1;
              if (ent_rem_next >= ENT_HDR_LEN) begin
                ent_len = scratch_next[11:0];
                // descriptor running past the loop is clipped to it
                if (ent_len > loop_rem_next) begin
                  flag_ovr_next = 1'b1;
                  ent_len       = loop_rem_next;
                end
                if (ent_len != '0) begin
                  phase_next   = nsp_pkg::PH_ENTDESC;
                  ent_rem_next = ent_len;
                end else begin
                  ent_rem_next = '0;
                  phase_next   = (loop_rem_next == '0) ? nsp_pkg::PH_TRAILER
                                                       : nsp_pkg::PH_ENTHDR;
                end
                if (!flag_dup) begin
                  res_valid           = 1'b1;
                  res.kind            = nsp_pkg::KIND_ENTRY;
                  res.stream_id       = scratch_next[47:32];
                  res.orig_network_id = scratch_next[31:16];
                  res.desc_length     = scratch_next[11:0];
                end
              end else if (loop_rem_next == '0) begin
                // loop ends inside an entry header
                flag_ovr_next = 1'b1;
                ent_rem_next  = '0;
                phase_next    = nsp_pkg::PH_TRAILER;
              end
            end
            nsp_pkg::PH_ENTDESC: begin
              loop_rem_next = loop_rem - 12'd1;
              ent_rem_next  = ent_rem - 12'd1;
              if (ent_rem_next == '0) begin
                phase_next = (loop_rem_next == '0) ? nsp_pkg::PH_TRAILER
                                                   : nsp_pkg::PH_ENTHDR;
              end
              if (!flag_dup) begin
                res_valid           = 1'b1;
                res.kind            = nsp_pkg::KIND_ENT_DESC;
                res.stream_id       = scratch[47:32];
                res.orig_network_id = scratch[31:16];
                res.desc_length     = scratch[11:0];
                res.out_byte        = d;
              end
            end
            nsp_pkg::PH_TRAILER: begin
              if (ent_rem != POS_MAX) begin
                ent_rem_next = ent_rem + 12'd1;
              end
            end
            default: ;
          endcase
        end

        // end of section replaces any data result of the same byte
        if (item.section_end) begin
          overrun = flag_ovr_next || (phase_next != nsp_pkg::PH_TRAILER) ||
                    (ent_rem_next != TRAILER_LEN) ||
                    (({1'b0, pos_next} + 13'd1) != ({1'b0, sec_len_next} + 13'd3));
          res       = '0;
          res_valid = 1'b1;
          res.kind  = nsp_pkg::KIND_END;
          if (phase_next == nsp_pkg::PH_SKIP) begin
            res.status    = nsp_pkg::STAT_WRONG_TABLE;
            net_id_next   = '0;
            sec_num_next  = '0;
            last_num_next = '0;
          end else begin
            if (crc_next != '0) begin
              res.status = nsp_pkg::STAT_CRC_ERR;
            end else if (overrun) begin
              res.status = nsp_pkg::STAT_OVERRUN;
            end else if (flag_dup_next) begin
              res.status = nsp_pkg::STAT_DUPLICATE;
            end else begin
              res.status       = nsp_pkg::STAT_OK;
              seen_req.set     = 1'b1;
              seen_req.set_idx = sec_num_next;
            end
            res.table_complete = seen_resp.done;
          end
          phase_next = nsp_pkg::PH_IDLE;
        end

        if (res_valid) begin
          res.network_id          = net_id_next;
          res.section_number      = sec_num_next;
          res.last_section_number = last_num_next;
        end
      end
    end
    seen_req.last_idx = last_num_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= nsp_pkg::PH_IDLE;
      pos      <= '0;
      net_rem  <= '0;
      loop_rem <= '0;
      ent_rem  <= '0;
      scratch  <= '0;
      net_id   <= '0;
      sec_num  <= '0;
      last_num <= '0;
      sec_len  <= '0;
      crc      <= nsp_pkg::CRC_INIT;
      flag_ovr <= 1'b0;
      flag_dup <= 1'b0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      net_rem  <= net_rem_next;
      loop_rem <= loop_rem_next;
      ent_rem  <= ent_rem_next;
      scratch  <= scratch_next;
      net_id   <= net_id_next;
      sec_num  <= sec_num_next;
      last_num <= last_num_next;
      sec_len  <= sec_len_next;
      crc      <= crc_next;
      flag_ovr <= flag_ovr_next;
      flag_dup <= flag_dup_next;
    end
  end

  a_end_gives_status : assert property (@(posedge clk) disable iff (rst)
    (step && !item.req_type && item.section_end &&
     (item.section_start || phase != nsp_pkg::PH_IDLE))
    |-> (res_valid && res.kind == nsp_pkg::KIND_END))
    else $error("section end without an end status item");

  a_end_returns_idle : assert property (@(posedge clk) disable iff (rst)
    (step && !item.req_type && item.section_end) |=> (phase == nsp_pkg::PH_IDLE))
    else $error("parser not idle after section end");

  a_data_only_in_section : assert property (@(posedge clk) disable iff (rst)
    (step && res_valid && res.kind != nsp_pkg::KIND_END)
    |-> (phase != nsp_pkg::PH_IDLE && phase != nsp_pkg::PH_SKIP))
    else $error("data item outside an accepted section");

endmodule

>>> rtl/nit_section_parser.sv
`timescale 1ns / 1ps
// top level of the nit section parser: input stage, result register, table id register
//
//   channel | signals                         | moves
//   --------+---------------------------------+-----------------------------------
//   in      | in_valid, in_ready, in_item     | one section byte or restart request
//   out     | out_valid, out_ready, out_item  | one header, descriptor, entry or end
//   cfg     | cfg_valid, cfg_ready, cfg_data  | expected table id write
//
// one item per cycle unless out_ready low holds the result register; a result leaves
// the result register after passing the input register and the single parse stage
// synchronous reset clears parser state and the seen-section map at once
// out_ready low holds the result register and then the input stage; in_ready
// drops only when both are full
module nit_section_parser #(
  parameter int MAX_SECTIONS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  nsp_pkg::nsp_in_t                  in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output nsp_pkg::nsp_out_t                 out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nsp_pkg::TABLE_ID_W-1:0]    cfg_data
);

  logic [nsp_pkg::TABLE_ID_W-1:0] expected_table_id;
  logic                iq_valid;
  nsp_pkg::nsp_in_t    iq_item;
  logic                proceed;
  logic                step;
  logic                res_valid;
  nsp_pkg::nsp_out_t   res;
  nsp_pkg::seen_req_t  seen_req;
  nsp_pkg::seen_resp_t seen_resp;

  assign proceed   = !out_valid || out_ready;
  assign step      = iq_valid && proceed;
  assign in_ready  = !iq_valid || proceed;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid          <= 1'b0;
      out_valid         <= 1'b0;
      expected_table_id <= nsp_pkg::TABLE_ID_RESET;
    end else begin
      if (in_valid && in_ready) begin
        iq_valid <= 1'b1;
      end else if (step) begin
        iq_valid <= 1'b0;
      end
      if (proceed) begin
        out_valid <= step && res_valid;
      end
      if (cfg_valid && cfg_ready) begin
        expected_table_id <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      iq_item <= in_item;
    end
    if (proceed) begin
      out_item <= res;
    end
  end

  nsp_parse u_parse (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .item              (iq_item),
    .expected_table_id (expected_table_id),
    .seen_resp         (seen_resp),
    .seen_req          (seen_req),
    .res_valid         (res_valid),
    .res               (res)
  );

  nsp_seen #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_seen (
    .clk  (clk),
    .rst  (rst),
    .req  (seen_req),
    .resp (seen_resp)
  );

  a_stalled_item_held : assert property (@(posedge clk) disable iff (rst)
    (iq_valid && !proceed) |=> (iq_valid && $stable(iq_item)))
    else $error("input stage lost or changed a stalled item");

endmodule
